/* sv/blb_pkg.sv */
// shared types and constants of the bounded list buffer
package blb_pkg;

	localparam int unsigned DATA_W     = 32;
	localparam int unsigned POS_W      = 5;
	localparam int unsigned CNT_W      = 5;
	localparam int unsigned IN_TDATA_W  = 40;
	localparam int unsigned IN_TUSER_W  = 3;
	localparam int unsigned OUT_TDATA_W = 40;

	// operation carried in s_tuser
	typedef enum logic [2:0] {
		FN_PUSH_BACK  = 3'd0,
		FN_PUSH_FRONT = 3'd1,
		FN_POP_BACK   = 3'd2,
		FN_POP_FRONT  = 3'd3,
		FN_INSERT     = 3'd4,
		FN_REMOVE     = 3'd5,
		FN_READ       = 3'd6,
		FN_CLEAR      = 3'd7
	} func_t;

	// result status
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_RANGE    = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	// one finished result from the controller
	typedef struct packed {
		logic               valid;
		logic [DATA_W-1:0]  read_data;
		logic [CNT_W-1:0]   count;
		status_t            status;
	} res_t;

endpackage

/* sv/blb_ram.sv */
// generic single-port-write, single-port-read ram with registered read
module blb_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sv/blb_ctrl.sv */
// list controller: circular store in ram, shift and search sequencer
module blb_ctrl #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              acc,
	input  blb_pkg::func_t                    func,
	input  logic signed [blb_pkg::DATA_W-1:0] value,
	input  logic [blb_pkg::POS_W-1:0]         position,
	input  logic                              out_free,
	output logic                              idle,
	output blb_pkg::res_t                     res
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned PW = (CW > blb_pkg::POS_W) ? CW : blb_pkg::POS_W;
	localparam logic [AW:0]   CAP_E   = (AW+1)'(CAPACITY);
	localparam logic [CW-1:0] CAP_C   = CW'(CAPACITY);
	localparam logic [AW-1:0] LAST_PH = AW'(CAPACITY - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_UP,
		S_UP_END,
		S_PUT,
		S_SRCH,
		S_DN
	} state_t;

	state_t state_q, state_nxt;
	logic [AW-1:0] head_q, head_nxt;
	logic [CW-1:0] count_q, cnt_nxt;
	logic          pend_s1, pend_nxt;
	logic [AW-1:0] tgt_s1, tgt_nxt;
	logic [CW-1:0] idx_q, idx_nxt;
	logic [AW-1:0] lo_q, lo_nxt;
	logic [blb_pkg::DATA_W-1:0] val_q, val_nxt;

	logic                       we, re;
	logic [AW-1:0]              waddr, raddr;
	logic [blb_pkg::DATA_W-1:0] wdata, rdata;

	logic          full, empty, issue;
	logic [PW-1:0] pos_w, cnt_w;
	logic [AW-1:0] pos_a, idx_a, head_dec, head_inc;

	// logical index to physical ram address
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
		input logic [AW-1:0] off);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= CAP_E) begin
			sum = sum - CAP_E;
		end
		return sum[AW-1:0];
	endfunction

	blb_ram #(
		.WIDTH (blb_pkg::DATA_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign full     = (count_q == CAP_C);
	assign empty    = (count_q == '0);
	assign pos_w    = PW'(position);
	assign cnt_w    = PW'(count_q);
	assign pos_a    = AW'(position);
	assign idx_a    = idx_q[AW-1:0];
	assign head_dec = (head_q == '0) ? LAST_PH : head_q - 1'b1;
	assign head_inc = (head_q == LAST_PH) ? '0 : head_q + 1'b1;
	assign issue    = (idx_q < count_q);
	assign idle     = (state_q == S_IDLE);

	// next state, ram access and result
	always_comb begin
		state_nxt = state_q;
		head_nxt  = head_q;
		cnt_nxt   = count_q;
		pend_nxt  = pend_s1;
		tgt_nxt   = tgt_s1;
		idx_nxt   = idx_q;
		lo_nxt    = lo_q;
		val_nxt   = val_q;
		we        = 1'b0;
		waddr     = '0;
		wdata     = '0;
		re        = 1'b0;
		raddr     = '0;
		res       = '0;
		res.status = blb_pkg::ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					res.valid = 1'b1;
					val_nxt   = value;
					lo_nxt    = pos_a;
					unique case (func)
						blb_pkg::FN_PUSH_BACK: begin
							if (full) begin
								res.status = blb_pkg::ST_FULL;
							end else begin
								we      = 1'b1;
								waddr   = phys(head_q, count_q[AW-1:0]);
								wdata   = value;
								cnt_nxt = count_q + 1'b1;
							end
						end
						blb_pkg::FN_PUSH_FRONT: begin
							if (full) begin
								res.status = blb_pkg::ST_FULL;
							end else begin
								we       = 1'b1;
								waddr    = head_dec;
								wdata    = value;
								head_nxt = head_dec;
								cnt_nxt  = count_q + 1'b1;
							end
						end
						blb_pkg::FN_POP_BACK: begin
							if (empty) begin
								res.status = blb_pkg::ST_EMPTY;
							end else begin
								cnt_nxt = count_q - 1'b1;
							end
						end
						blb_pkg::FN_POP_FRONT: begin
							if (empty) begin
								res.status = blb_pkg::ST_EMPTY;
							end else begin
								head_nxt = head_inc;
								cnt_nxt  = count_q - 1'b1;
							end
						end
						blb_pkg::FN_INSERT: begin
							if (full) begin
								res.status = blb_pkg::ST_FULL;
							end else if (pos_w > cnt_w) begin
								res.status = blb_pkg::ST_RANGE;
							end else if (pos_w == cnt_w) begin
								// append at the end
								we      = 1'b1;
								waddr   = phys(head_q, pos_a);
								wdata   = value;
								cnt_nxt = count_q + 1'b1;
							end else begin
								res.valid = 1'b0;
								idx_nxt   = count_q - 1'b1;
								pend_nxt  = 1'b0;
								state_nxt = S_UP;
							end
						end
						blb_pkg::FN_REMOVE: begin
							if (empty) begin
								res.status = blb_pkg::ST_EMPTY;
							end else begin
								res.valid = 1'b0;
								idx_nxt   = '0;
								pend_nxt  = 1'b0;
								state_nxt = S_SRCH;
							end
						end
						blb_pkg::FN_READ: begin
							if (pos_w >= cnt_w) begin
								res.status = blb_pkg::ST_RANGE;
							end else begin
								res.valid = 1'b0;
								re        = 1'b1;
								raddr     = phys(head_q, pos_a);
								state_nxt = S_READ;
							end
						end
						blb_pkg::FN_CLEAR: begin
							cnt_nxt = '0;
						end
						default: begin
							res.valid = 1'b0;
						end
					endcase
					res.count = blb_pkg::CNT_W'(cnt_nxt);
				end
			end
			// read data arrives from the ram
			S_READ: begin
				if (out_free) begin
					res.valid     = 1'b1;
					res.read_data = rdata;
					res.count     = blb_pkg::CNT_W'(count_q);
					state_nxt     = S_IDLE;
				end
			end
			// move entries up one place, from the back toward the insert point
			S_UP: begin
				re       = 1'b1;
				raddr    = phys(head_q, idx_a);
				pend_nxt = 1'b1;
				tgt_nxt  = idx_a + 1'b1;
				if (pend_s1) begin
					we    = 1'b1;
					waddr = phys(head_q, tgt_s1);
					wdata = rdata;
				end
				if (idx_a == lo_q) begin
					state_nxt = S_UP_END;
				end else begin
					idx_nxt = idx_q - 1'b1;
				end
			end
			S_UP_END: begin
				we        = 1'b1;
				waddr     = phys(head_q, tgt_s1);
				wdata     = rdata;
				pend_nxt  = 1'b0;
				state_nxt = S_PUT;
			end
			// store the new word at the insert point
			S_PUT: begin
				if (out_free) begin
					we        = 1'b1;
					waddr     = phys(head_q, lo_q);
					wdata     = val_q;
					cnt_nxt   = count_q + 1'b1;
					res.valid = 1'b1;
					res.count = blb_pkg::CNT_W'(cnt_nxt);
					state_nxt = S_IDLE;
				end
			end
			// first-match search, one entry per cycle
			S_SRCH: begin
				if (issue) begin
					re       = 1'b1;
					raddr    = phys(head_q, idx_a);
					pend_nxt = 1'b1;
					tgt_nxt  = idx_a;
					idx_nxt  = idx_q + 1'b1;
				end else begin
					pend_nxt = 1'b0;
				end
				if (pend_s1 && (rdata == val_q)) begin
					idx_nxt   = CW'(tgt_s1) + 1'b1;
					pend_nxt  = 1'b0;
					state_nxt = S_DN;
				end else if (!pend_s1 && !issue && out_free) begin
					res.valid  = 1'b1;
					res.status = blb_pkg::ST_NOTFOUND;
					res.count  = blb_pkg::CNT_W'(count_q);
					state_nxt  = S_IDLE;
				end
			end
			// close the gap left by the removed entry
			S_DN: begin
				if (issue) begin
					re       = 1'b1;
					raddr    = phys(head_q, idx_a);
					pend_nxt = 1'b1;
					tgt_nxt  = idx_a - 1'b1;
					idx_nxt  = idx_q + 1'b1;
				end else begin
					pend_nxt = 1'b0;
				end
				if (pend_s1) begin
					we    = 1'b1;
					waddr = phys(head_q, tgt_s1);
					wdata = rdata;
				end
				if (!issue && !pend_s1 && out_free) begin
					cnt_nxt   = count_q - 1'b1;
					res.valid = 1'b1;
					res.count = blb_pkg::CNT_W'(cnt_nxt);
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_nxt;
			head_q  <= head_nxt;
			count_q <= cnt_nxt;
			pend_s1 <= pend_nxt;
		end
	end

	// sequencer payload
	always_ff @(posedge clk) begin
		tgt_s1 <= tgt_nxt;
		idx_q  <= idx_nxt;
		lo_q   <= lo_nxt;
		val_q  <= val_nxt;
	end

endmodule

/* sv/bounded_list_buffer.sv */
// bounded list buffer top level: stream ports and result register
// push, pop, clear, append and failed checks give their result in the result register in the
// cycle after the transfer; read makes one ram read; insert at p below count moves each entry
// from p up one place with one ram read and write; remove finds the first match and moves the
// later entries down one place, or reports not found
// a new transfer is taken once the previous item is finished and the result register is free
// reset: arst_n clears count, head and sequencer at once; list words are not cleared
module bounded_list_buffer #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [blb_pkg::IN_TDATA_W-1:0]     s_tdata,  // value[31:0], position[36:32], zero
	input  logic [blb_pkg::IN_TUSER_W-1:0]     s_tuser,  // func[2:0]
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [blb_pkg::OUT_TDATA_W-1:0]    m_tdata   // read_data[31:0], count[36:32], status[39:37]
);

	logic          m_tvalid_q;
	logic [blb_pkg::OUT_TDATA_W-1:0] m_tdata_q;
	logic          out_free, idle, acc;
	blb_pkg::res_t res;

	// input transfer
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = idle && out_free;
	assign acc      = s_tvalid && s_tready;

	blb_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.func     (blb_pkg::func_t'(s_tuser[2:0])),
		.value    (s_tdata[31:0]),
		.position (s_tdata[36:32]),
		.out_free (out_free),
		.idle     (idle),
		.res      (res)
	);

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res.valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (res.valid) begin
			m_tdata_q <= {res.status, res.count, res.read_data};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

/* sv/blb_checker.sv */
// port-level checker for the bounded list buffer and its bind
module blb_checker #(
	parameter int unsigned CAPACITY = 16
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [blb_pkg::OUT_TDATA_W-1:0] m_tdata
);

	localparam logic [4:0] CAP_CNT = 5'(CAPACITY);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// input is taken only when the result register can move
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!m_tvalid || m_tready))
		else $error("input ready while result is stalled");

	// read data is zero unless the status is ok
	a_rdata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[39:37] != blb_pkg::ST_OK) |-> (m_tdata[31:0] == '0))
		else $error("read data not zero on failed item");

	// full status only at capacity
	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[39:37] == blb_pkg::ST_FULL) |-> (m_tdata[36:32] == CAP_CNT))
		else $error("full reported below capacity");

	// empty status only with no entries
	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[39:37] == blb_pkg::ST_EMPTY) |-> (m_tdata[36:32] == '0))
		else $error("empty reported with entries present");

endmodule

bind bounded_list_buffer blb_checker #(.CAPACITY(CAPACITY)) u_blb_checker (.*);
